FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the circle inversion RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a condition implies a consequence on the same edge.
`define ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
// Checks that a condition implies a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`endif

FILE: rtl/core/cinv_pkg.sv
// Package for the circle inversion pixel map: widths, register indexes, constants.
// Depends on nothing.
package cinv_pkg;
   localparam int CoordWidth  = 32;
   localparam int FracBits    = 16;
   localparam int RadiusWidth = 31;
   localparam int AddrWidth   = 4;
   localparam logic [1:0] RegRadius  = 2'd0;
   localparam logic [1:0] RegCenterX = 2'd1;
   localparam logic [1:0] RegCenterY = 2'd2;
   localparam logic [1:0] RegInvIn   = 2'd3;
   localparam int NearLimit   = 4295;
   localparam int FarOffset   = 1000000;
   localparam int InvalidCoord = -1000;
endpackage

FILE: rtl/core/cinv_if.sv
// Valid/ready channel interface carrying one pixel item.
// Depends on cinv_pkg for the default coordinate width.
interface cinv_if #(parameter int COORD_WIDTH = cinv_pkg::CoordWidth);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x;
   logic signed [COORD_WIDTH-1:0] y;
   logic                          pix_valid;
   logic                          parity;
   modport source (output valid, x, y, pix_valid, parity, input ready);
   modport sink (input valid, x, y, pix_valid, parity, output ready);
endinterface

FILE: rtl/core/cinv_div.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned.
// Depends on nothing; the valid bits live with the caller.
module cinv_div #(
   parameter int NW = 96,
   parameter int DW = 64,
   parameter int TW = 4
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   input  logic [TW-1:0] tag_in,
   output logic [NW-1:0] quo,
   output logic [TW-1:0] tag_out
);
   // Stage s holds the partial remainder and the unused numerator bits.
   logic [DW:0]   rem_ff [1:NW-1];
   logic [DW-1:0] den_ff [1:NW-1];
   logic [NW-1:0] num_ff [1:NW];
   logic [TW-1:0] tag_ff [1:NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [DW:0]   rem_cur;
      logic [DW-1:0] den_cur;
      logic [NW-1:0] num_cur;
      logic [TW-1:0] tag_cur;
      logic [DW+1:0] trial;
      logic [DW:0]   rem_in;
      logic [NW-1:0] num_in_s;
      // The first stage starts from the inputs with an empty remainder.
      if (s == 0) begin : g_first
         assign rem_cur = '0;
         assign den_cur = den_in;
         assign num_cur = num_in;
         assign tag_cur = tag_in;
      end else begin : g_next
         assign rem_cur = rem_ff[s];
         assign den_cur = den_ff[s];
         assign num_cur = num_ff[s];
         assign tag_cur = tag_ff[s];
      end
      always_comb begin
         trial = {rem_cur, num_cur[NW-1]} - {2'b00, den_cur};
         if (!trial[DW+1]) rem_in = trial[DW:0];
         else rem_in = {rem_cur[DW-1:0], num_cur[NW-1]};
         // Shifted numerator collects quotient bits at its low end.
         num_in_s = {num_cur[NW-2:0], ~trial[DW+1]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[s+1] <= num_in_s;
            tag_ff[s+1] <= tag_cur;
         end
      end
      // The remainder and divisor are not needed past the last stage.
      if (s < NW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s+1] <= rem_in;
               den_ff[s+1] <= den_cur;
            end
         end
      end
   end

   assign quo     = num_ff[NW];
   assign tag_out = tag_ff[NW];
endmodule

FILE: rtl/core/circle_inversion_pixel_map.sv
// Top level of the circle inversion pixel map with APB-style register port.
// Depends on cinv_pkg, cinv_if, cinv_div and assert_macros.svh.
//
//   channel  | direction | handshake
//   req      | in        | valid/ready, item = x, y, pix_valid, parity
//   rsp      | out       | valid/ready, item = x, y, pix_valid, parity
//   csr      | in        | APB write/read, pready always high
//
// One item per cycle enters while the output is not stalled; a result item passes through
// four front stages, COORD_WIDTH+63 quotient stages of one bit each, and the output
// register after its input item is accepted.
// The whole pipeline advances only when the output register can take data,
// so a stall holds every stage. Synchronous active-high reset clears valid
// bits and loads register reset values.
`include "assert_macros.svh"
module circle_inversion_pixel_map #(
   parameter int COORD_WIDTH = cinv_pkg::CoordWidth
) (
   input  logic                            clock,
   input  logic                            reset,
   cinv_if.sink                            req,
   cinv_if.source                          rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cinv_pkg::AddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import cinv_pkg::*;
   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;          // |d| width
   localparam int SW  = 2 * DW + 1;      // squared distance width
   localparam int R2W = 2 * RadiusWidth; // radius squared width
   localparam int NW  = DW + R2W;        // dividend width
   localparam int PW  = DW + RadiusWidth; // partial product width
   localparam logic signed [CW+1:0] CMAX = (CW+2)'((65'sd1 <<< (CW-1)) - 1);
   localparam logic signed [CW+1:0] CMIN = -CMAX - 1;
   localparam longint FarFull   = longint'(FarOffset) * 65536;
   localparam longint CoordSpan = longint'(1) <<< CW;
   // Any offset beyond the coordinate span saturates, so it is capped to fit.
   localparam logic signed [CW+1:0] FAR =
      (CW+2)'((FarFull > CoordSpan) ? CoordSpan : FarFull);
   localparam longint BadFull = longint'(InvalidCoord) * 65536;
   localparam logic signed [CW+1:0] BAD_RAW =
      (CW+2)'((BadFull < -(CoordSpan >>> 1)) ? -(CoordSpan >>> 1) : BadFull);

   function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
      if (v > CMAX) return CMAX[CW-1:0];
      if (v < CMIN) return CMIN[CW-1:0];
      return v[CW-1:0];
   endfunction

   // Configuration registers.
   logic [RadiusWidth-1:0] radius_ff;
   logic signed [CW-1:0]   cx_ff, cy_ff;
   logic                   inv_in_ff;
   logic                   wr;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RadiusWidth'(65536);
         cx_ff <= '0;
         cy_ff <= '0;
         inv_in_ff <= 1'b1;
      end else if (wr) begin
         case (csr_paddr[3:2])
            RegRadius:  radius_ff <= csr_pwdata[RadiusWidth-1:0];
            RegCenterX: cx_ff <= CW'($signed(csr_pwdata));
            RegCenterY: cy_ff <= CW'($signed(csr_pwdata));
            default:    inv_in_ff <= csr_pwdata[0];
         endcase
      end
   end
   always_comb begin
      case (csr_paddr[3:2])
         RegRadius:  csr_prdata = 32'(radius_ff);
         RegCenterX: csr_prdata = 32'(cx_ff);
         RegCenterY: csr_prdata = 32'(cy_ff);
         default:    csr_prdata = 32'(inv_in_ff);
      endcase
   end

   // Global advance: output register free or being drained.
   logic out_v_ff, adv;
   assign adv = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   // Stage 1: differences and magnitudes.
   logic          v1_ff, pv1_ff, par1_ff, sx1_ff, sy1_ff;
   logic [DW-1:0] mx1_ff, my1_ff;
   logic signed [CW-1:0] x1_ff, y1_ff;
   logic signed [DW-1:0] dx, dy;
   assign dx = DW'(req.x) - DW'(cx_ff);
   assign dy = DW'(req.y) - DW'(cy_ff);
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req.valid;
      if (adv) begin
         pv1_ff <= req.pix_valid; par1_ff <= req.parity;
         sx1_ff <= dx[DW-1]; sy1_ff <= dy[DW-1];
         mx1_ff <= dx[DW-1] ? DW'(-dx) : DW'(dx);
         my1_ff <= dy[DW-1] ? DW'(-dy) : DW'(dy);
         x1_ff <= req.x; y1_ff <= req.y;
      end
   end

   // Stage 2: squares and radius squared.
   logic          v2_ff, pv2_ff, par2_ff, sx2_ff, sy2_ff;
   logic [DW-1:0] mx2_ff, my2_ff;
   logic [2*DW-1:0] qx2_ff, qy2_ff;
   logic [R2W-1:0]  r2_2_ff;
   logic signed [CW-1:0] x2_ff, y2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         pv2_ff <= pv1_ff; par2_ff <= par1_ff; sx2_ff <= sx1_ff; sy2_ff <= sy1_ff;
         mx2_ff <= mx1_ff; my2_ff <= my1_ff; x2_ff <= x1_ff; y2_ff <= y1_ff;
         qx2_ff <= mx1_ff * mx1_ff;
         qy2_ff <= my1_ff * my1_ff;
         r2_2_ff <= radius_ff * radius_ff;
      end
   end

   // Stage 3: squared distance, and the dividend split in two partial products.
   logic          v3_ff, pv3_ff, par3_ff, sx3_ff, sy3_ff;
   logic [PW-1:0] pxl3_ff, pxh3_ff, pyl3_ff, pyh3_ff;
   logic [SW-1:0] d2_3_ff;
   logic [R2W-1:0] r2_3_ff;
   logic signed [CW-1:0] x3_ff, y3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         pv3_ff <= pv2_ff; par3_ff <= par2_ff; sx3_ff <= sx2_ff; sy3_ff <= sy2_ff;
         x3_ff <= x2_ff; y3_ff <= y2_ff;
         pxl3_ff <= mx2_ff * r2_2_ff[RadiusWidth-1:0];
         pxh3_ff <= mx2_ff * r2_2_ff[R2W-1:RadiusWidth];
         pyl3_ff <= my2_ff * r2_2_ff[RadiusWidth-1:0];
         pyh3_ff <= my2_ff * r2_2_ff[R2W-1:RadiusWidth];
         d2_3_ff <= SW'(qx2_ff) + SW'(qy2_ff);
         r2_3_ff <= r2_2_ff;
      end
   end

   // Stage 4: dividends and action code.
   localparam logic [1:0] ActKeep = 2'd0, ActInv = 2'd1, ActFar = 2'd2;
   logic [1:0] act;
   logic lt, gt;
   assign lt = d2_3_ff < SW'(r2_3_ff);
   assign gt = d2_3_ff > SW'(r2_3_ff);
   always_comb begin
      if (inv_in_ff && lt)
         act = (d2_3_ff < SW'(NearLimit)) ? ActFar : ActInv;
      else if (!inv_in_ff && gt) act = ActInv;
      else act = ActKeep;
   end
   localparam int TW = 2 * CW + 5;
   logic          v4_ff;
   logic [NW-1:0] nx4_ff, ny4_ff;
   logic [SW-1:0] d2_4_ff;
   logic [TW-1:0] tag4_ff;
   logic          sy4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
      if (adv) begin
         nx4_ff <= NW'(pxl3_ff) + (NW'(pxh3_ff) << RadiusWidth);
         ny4_ff <= NW'(pyl3_ff) + (NW'(pyh3_ff) << RadiusWidth);
         d2_4_ff <= (d2_3_ff == '0) ? SW'(1) : d2_3_ff;
         tag4_ff <= {x3_ff, y3_ff, act, pv3_ff, par3_ff, sx3_ff};
         sy4_ff <= sy3_ff;
      end
   end

   // Division pipelines, one per axis; the x pipeline carries the shared control, the y one its sign.
   logic [NW-1:0] qx, qy;
   logic [TW-1:0] tag5;
   logic          tag5y;
   logic          v5;
   cinv_div #(.NW(NW), .DW(SW), .TW(TW)) u_divx (
      .clock, .en(adv), .num_in(nx4_ff), .den_in(d2_4_ff),
      .tag_in(tag4_ff), .quo(qx), .tag_out(tag5));
   cinv_div #(.NW(NW), .DW(SW), .TW(1)) u_divy (
      .clock, .en(adv), .num_in(ny4_ff), .den_in(d2_4_ff),
      .tag_in(sy4_ff), .quo(qy), .tag_out(tag5y));
   // Valid bits for the divider stages.
   logic [NW-1:0] vd_ff;
   always_ff @(posedge clock) begin
      if (reset) vd_ff <= '0;
      else if (adv) vd_ff <= {vd_ff[NW-2:0], v4_ff};
   end
   assign v5 = vd_ff[NW-1];

   // Stage 5: clamp quotients and add the center; far items get the far offset, kept items pass through.
   logic signed [CW-1:0] tx, ty;
   logic [1:0] tact;
   logic tpv, tpar, tsx, tsy;
   assign {tx, ty, tact, tpv, tpar, tsx} = tag5;
   assign tsy = tag5y;
   logic signed [CW+1:0] ox, oy;
   logic [CW:0] mqx, mqy;
   localparam logic [CW:0] LIM = (CW+1)'(1) << CW;
   assign mqx = (qx > NW'(LIM)) ? LIM : qx[CW:0];
   assign mqy = (qy > NW'(LIM)) ? LIM : qy[CW:0];
   always_comb begin
      case (tact)
         ActInv: begin
            ox = (CW+2)'(cx_ff) + (tsx ? -(CW+2)'(mqx) : (CW+2)'(mqx));
            oy = (CW+2)'(cy_ff) + (tsy ? -(CW+2)'(mqy) : (CW+2)'(mqy));
         end
         ActFar: begin
            ox = (CW+2)'(cx_ff) + FAR;
            oy = (CW+2)'(cy_ff) + FAR;
         end
         default: begin
            ox = (CW+2)'(tx);
            oy = (CW+2)'(ty);
         end
      endcase
   end
   logic signed [CW-1:0] out_x_ff, out_y_ff;
   logic out_pv_ff, out_par_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= v5;
      if (adv) begin
         out_pv_ff <= tpv;
         out_par_ff <= tpv & (tpar ^ (tact != ActKeep));
         out_x_ff <= tpv ? sat(ox) : sat(BAD_RAW);
         out_y_ff <= tpv ? sat(oy) : sat(BAD_RAW);
      end
   end
   assign rsp.valid = out_v_ff;
   assign rsp.x = out_x_ff;
   assign rsp.y = out_y_ff;
   assign rsp.pix_valid = out_pv_ff;
   assign rsp.parity = out_par_ff;

   // Checks on the pipeline.
   `ASSERT_NEXT(a_stall_hold, clock, reset, out_v_ff && !rsp.ready, out_v_ff && $stable(out_x_ff), "result changed under stall")
   `ASSERT_IMPL(a_bad_par, clock, reset, out_v_ff && !out_pv_ff, !out_par_ff, "invalid pixel with parity")
   `ASSERT_IMPL(a_ready, clock, reset, !out_v_ff, req.ready, "not ready with empty output")
endmodule
